// ===== hdl/fmf_pkg.sv =====
// Shared types and constants for the response message fragmenter.
package fmf_pkg;

  localparam int unsigned BEATS_MAX = 4;
  localparam logic [6:0] FIRST_HEADER_FILL = 7'd3;
  localparam logic [6:0] SEQ_HEADER_FILL = 7'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [BEATS_MAX-1:0][7:0] bytes;
    logic [1:0]                last;
    logic                      pend;
    logic                      mend;
  } job_t;

endpackage

// ===== hdl/fmf_front.sv =====
// Front part: tracks the framing state and turns each input item into a job of beats.
module fmf_front #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first,
  input  logic [7:0]        in_command,
  input  logic [15:0]       in_message_length,
  input  logic              q_full,
  output logic              q_push,
  output fmf_pkg::job_t     q_job
);

  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [6:0]  packet_fill_r, packet_fill_nxt;
  logic [7:0]  packet_index_r, packet_index_nxt;
  logic        message_open_r, message_open_nxt;

  logic        accept;
  logic        opening;
  logic        open0;
  logic [15:0] left0;
  logic [15:0] left1;
  logic [6:0]  fill0;
  logic [6:0]  fill1;
  logic [6:0]  fill2;
  logic [7:0]  index0;
  logic [7:0]  seq_byte;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    opening = 1'b0;
    open0   = message_open_r;
    left0   = bytes_left_r;
    fill0   = packet_fill_r;
    index0  = packet_index_r;
    if (in_first) begin
      fill0  = '0;
      index0 = '0;
      left0  = in_message_length;
      if (in_message_length == 16'd0) begin
        open0 = 1'b0;
      end else begin
        open0   = 1'b1;
        opening = 1'b1;
      end
    end

    seq_byte = index0 - 8'd1;
    left1    = left0 - 16'd1;
    if (fill0 == 7'd0) begin
      fill1 = opening ? fmf_pkg::FIRST_HEADER_FILL : fmf_pkg::SEQ_HEADER_FILL;
    end else begin
      fill1 = fill0;
    end
    fill2 = fill1 + 7'd1;

    q_job       = '0;
    q_job.pend  = 1'b0;
    q_job.mend  = 1'b0;
    if (fill0 == 7'd0 && opening) begin
      q_job.bytes[0] = in_command;
      q_job.bytes[1] = in_message_length[15:8];
      q_job.bytes[2] = in_message_length[7:0];
      q_job.bytes[3] = in_data_byte;
      q_job.last     = 2'd3;
    end else if (fill0 == 7'd0) begin
      q_job.bytes[0] = seq_byte;
      q_job.bytes[1] = in_data_byte;
      q_job.last     = 2'd1;
    end else begin
      q_job.bytes[0] = in_data_byte;
      q_job.last     = 2'd0;
    end

    bytes_left_nxt   = left0;
    packet_fill_nxt  = fill0;
    packet_index_nxt = index0;
    message_open_nxt = open0;
    if (in_first && in_message_length == 16'd0) begin
      bytes_left_nxt = '0;
    end
    if (open0) begin
      bytes_left_nxt = left1;
      if (left1 == 16'd0) begin
        q_job.pend       = 1'b1;
        q_job.mend       = 1'b1;
        message_open_nxt = 1'b0;
        packet_fill_nxt  = '0;
        packet_index_nxt = index0 + 8'd1;
      end else if (fill2 >= 7'(MAX_PACKET_BYTES)) begin
        q_job.pend       = 1'b1;
        packet_fill_nxt  = '0;
        packet_index_nxt = index0 + 8'd1;
      end else begin
        packet_fill_nxt = fill2;
      end
    end

    q_push = accept && open0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= '0;
      packet_fill_r  <= '0;
      packet_index_r <= '0;
      message_open_r <= 1'b0;
    end else if (accept) begin
      bytes_left_r   <= bytes_left_nxt;
      packet_fill_r  <= packet_fill_nxt;
      packet_index_r <= packet_index_nxt;
      message_open_r <= message_open_nxt;
    end
  end

endmodule

// ===== hdl/fmf_fifo.sv =====
// Short job queue between the front and back parts.
module fmf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  fmf_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_valid,
  output fmf_pkg::job_t rd_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fmf_pkg::job_t   mem [DEPTH];
  logic [AW:0]     wptr_r, wptr_nxt;
  logic [AW:0]     rptr_r, rptr_nxt;

  assign q_valid  = (wptr_r != rptr_r);
  assign q_full   = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign rd_job   = mem[rptr_r[AW-1:0]];
  assign wptr_nxt = wptr_r + (AW+1)'(1);
  assign rptr_nxt = rptr_r + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r[AW-1:0]] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wptr_nxt;
      end
      if (rd_en) begin
        rptr_r <= rptr_nxt;
      end
    end
  end

endmodule

// ===== hdl/fmf_back.sv =====
// Back part: walks the beats of each queued job into the output register.
module fmf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  fmf_pkg::job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_packet_end,
  output logic          out_message_end,
  output logic          out_item_last
);

  logic [1:0] beat_idx_r, beat_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       packet_end_r, message_end_r, item_last_r;
  logic       load;
  logic       is_last;

  assign load    = q_valid && (!out_valid_r || pop);
  assign is_last = (beat_idx_r == q_job.last);
  assign q_pop   = load && is_last;

  always_comb begin
    beat_idx_nxt = beat_idx_r;
    if (load) begin
      beat_idx_nxt = is_last ? 2'd0 : beat_idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_idx_r  <= beat_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= q_job.bytes[beat_idx_r];
      packet_end_r  <= is_last && q_job.pend;
      message_end_r <= is_last && q_job.mend;
      item_last_r   <= is_last;
    end
  end

  assign empty           = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_packet_end  = packet_end_r;
  assign out_message_end = message_end_r;
  assign out_item_last   = item_last_r;

endmodule

// ===== hdl/response_message_fragmenter.sv =====
// Top level of the response message fragmenter.
//
// Input channel: one payload byte per beat with push/full; a beat is taken on
// a clock edge with push high and full low. A beat with in_first high samples
// in_message_length and, if it is nonzero, in_command and opens a new message.
// Result channel: one framed byte per beat with empty/pop; the oldest byte sits
// on the out_ ports while empty is low and leaves on an edge with pop high.
// Each input beat yields up to four result beats: three header bytes at the
// start of a message or one sequence byte at the start of a later packet,
// then the payload byte. Bytes outside an open message yield nothing.
// With the queue idle, the first result beat passes through the job queue and
// then the output register before it reaches the out_ ports.
// While full is low, the front part takes one input beat per cycle into a job
// queue of QUEUE_DEPTH entries; the back part sends one result beat per cycle
// while pop is held; an input beat that starts a packet yields two or four beats.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and full rises until room opens again.
// Reset clears the framing state, the queue and the output valid flag.
module response_message_fragmenter #(
  parameter int MAX_PACKET_BYTES = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,
  input  logic [7:0]  in_command,
  input  logic [15:0] in_message_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_message_end,
  output logic        out_item_last
);

  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  fmf_pkg::job_t front_job;
  fmf_pkg::job_t head_job;

  fmf_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .in_command       (in_command),
    .in_message_length(in_message_length),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (front_job)
  );

  fmf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_job (front_job),
    .q_full (q_full),
    .rd_en  (q_pop),
    .q_valid(q_valid),
    .rd_job (head_job)
  );

  fmf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_message_end(out_message_end),
    .out_item_last  (out_item_last)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("job written into a full queue");

  a_mend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_message_end) |-> (out_packet_end && out_item_last))
    else $error("message end without packet end on the last beat");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job taken from an empty queue");
`endif

endmodule
